@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also checks during reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/core/rvex_pkg.sv @@
// types, opcode and funct3 codes for the rv32i execute unit
`default_nettype none

package rvex_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned SHAMT_W = 5;

  // base opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;

  // alu funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // link address step
  localparam logic [XLEN-1:0] LINK_STEP = 32'd4;

  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_LUI,
    KIND_AUIPC,
    KIND_JAL,
    KIND_JALR,
    KIND_BRANCH,
    KIND_LOAD,
    KIND_STORE,
    KIND_ALU_IMM,
    KIND_ALU_REG
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [2:0]      funct3;
    logic            alt;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_s;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] imm_u;
    logic [XLEN-1:0] imm_j;
  } dec_t;

  typedef struct packed {
    logic [XLEN-1:0] alu_value;
    logic            dest_write;
    logic            load_flag;
    logic            store_flag;
    logic            branch_flag;
    logic            taken_flag;
    logic [XLEN-1:0] target_addr;
    logic [XLEN-1:0] store_data;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/rvex_if.sv @@
// request and result channel interfaces of the execute unit
`default_nettype none

interface rvex_issue_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] src1_value;
  logic [31:0] src2_value;
  logic [31:0] instr_pc;

  modport source(output valid, output instr_word, output src1_value,
                 output src2_value, output instr_pc, input ready);
  modport sink(input valid, input instr_word, input src1_value,
               input src2_value, input instr_pc, output ready);
endinterface

interface rvex_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] alu_value;
  logic        dest_write;
  logic        load_flag;
  logic        store_flag;
  logic        branch_flag;
  logic        taken_flag;
  logic [31:0] target_addr;
  logic [31:0] store_data;

  modport source(output valid, output alu_value, output dest_write,
                 output load_flag, output store_flag, output branch_flag,
                 output taken_flag, output target_addr, output store_data,
                 input ready);
  modport sink(input valid, input alu_value, input dest_write,
               input load_flag, input store_flag, input branch_flag,
               input taken_flag, input target_addr, input store_data,
               output ready);
endinterface

`default_nettype wire

@@ rtl/core/rv32i_execute_unit_top.sv @@
// rv32i execute unit: input register, decode and alu, result register
// an accepted request waits in the input register until the result register is free
// throughput: one request per cycle while the result is taken, set by the single
//   decode/alu pass between the input register and the result register
// under back-pressure the result holds while one more request waits in the input register
// reset (rst, synchronous) empties both registers; payload registers are not cleared
`default_nettype none

module rv32i_execute_unit_top (
  input logic          clk,
  input logic          rst,
  rvex_issue_if.sink   issue,
  rvex_result_if.source result
);

  logic           stage_valid;
  logic [31:0]    stage_instr;
  logic [31:0]    stage_src1;
  logic [31:0]    stage_src2;
  logic [31:0]    stage_pc;
  logic           out_valid;
  rvex_pkg::res_t out_res;
  logic           out_free;
  rvex_pkg::dec_t dec;
  rvex_pkg::res_t res_next;

  // handshake: result register frees when empty or taken
  assign out_free    = !out_valid || result.ready;
  assign issue.ready = !stage_valid || out_free;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (issue.ready) begin
        stage_valid <= issue.valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (issue.valid && issue.ready) begin
      stage_instr <= issue.instr_word;
      stage_src1  <= issue.src1_value;
      stage_src2  <= issue.src2_value;
      stage_pc    <= issue.instr_pc;
    end
  end

  rvex_decode u_decode (
    .instr_word (stage_instr),
    .dec        (dec)
  );

  rvex_alu u_alu (
    .dec        (dec),
    .src1_value (stage_src1),
    .src2_value (stage_src2),
    .instr_pc   (stage_pc),
    .res        (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      out_res <= res_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.alu_value   = out_res.alu_value;
  assign result.dest_write  = out_res.dest_write;
  assign result.load_flag   = out_res.load_flag;
  assign result.store_flag  = out_res.store_flag;
  assign result.branch_flag = out_res.branch_flag;
  assign result.taken_flag  = out_res.taken_flag;
  assign result.target_addr = out_res.target_addr;
  assign result.store_data  = out_res.store_data;

endmodule

`default_nettype wire

@@ rtl/core/rvex_decode.sv @@
// instruction decoder: opcode class, funct fields and immediates
`default_nettype none

module rvex_decode (
  input  logic [31:0]   instr_word,
  output rvex_pkg::dec_t dec
);

  logic [6:0]      opcode;
  rvex_pkg::kind_t kind;

  assign opcode = instr_word[6:0];

  // opcode class
  always_comb begin
    unique case (opcode)
      rvex_pkg::OPC_LUI:    kind = rvex_pkg::KIND_LUI;
      rvex_pkg::OPC_AUIPC:  kind = rvex_pkg::KIND_AUIPC;
      rvex_pkg::OPC_JAL:    kind = rvex_pkg::KIND_JAL;
      rvex_pkg::OPC_JALR:   kind = rvex_pkg::KIND_JALR;
      rvex_pkg::OPC_BRANCH: kind = rvex_pkg::KIND_BRANCH;
      rvex_pkg::OPC_LOAD:   kind = rvex_pkg::KIND_LOAD;
      rvex_pkg::OPC_STORE:  kind = rvex_pkg::KIND_STORE;
      rvex_pkg::OPC_IMM:    kind = rvex_pkg::KIND_ALU_IMM;
      rvex_pkg::OPC_REG:    kind = rvex_pkg::KIND_ALU_REG;
      default:              kind = rvex_pkg::KIND_NONE;
    endcase
  end

  assign dec.kind = kind;

  // funct fields, only funct7 bit 5 matters
  assign dec.funct3 = instr_word[14:12];
  assign dec.alt    = instr_word[30];

  // sign-extended immediates
  assign dec.imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
  assign dec.imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
  assign dec.imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                      instr_word[30:25], instr_word[11:8], 1'b0};
  assign dec.imm_u = {instr_word[31:12], 12'b0};
  assign dec.imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                      instr_word[20], instr_word[30:21], 1'b0};

endmodule

`default_nettype wire

@@ rtl/core/rvex_alu.sv @@
// alu, branch compare and target adder with result field selection
`default_nettype none

module rvex_alu (
  input  rvex_pkg::dec_t dec,
  input  logic [31:0]    src1_value,
  input  logic [31:0]    src2_value,
  input  logic [31:0]    instr_pc,
  output rvex_pkg::res_t res
);

  logic [31:0] opa;
  logic [31:0] opb;
  logic        sub;
  logic [31:0] sum;
  logic        eq;
  logic        lt;
  logic        ltu;
  logic [rvex_pkg::SHAMT_W-1:0] shamt;
  logic [31:0] alu_out;
  logic [31:0] tgt_a;
  logic [31:0] tgt_b;
  logic [31:0] tgt_sum;
  logic        taken;

  // adder operand a: pc for pc-relative and link forms
  always_comb begin
    if (dec.kind == rvex_pkg::KIND_AUIPC || dec.kind == rvex_pkg::KIND_JAL ||
        dec.kind == rvex_pkg::KIND_JALR) begin
      opa = instr_pc;
    end else begin
      opa = src1_value;
    end
  end

  // operand b select
  always_comb begin
    unique case (dec.kind)
      rvex_pkg::KIND_AUIPC:   opb = dec.imm_u;
      rvex_pkg::KIND_JAL,
      rvex_pkg::KIND_JALR:    opb = rvex_pkg::LINK_STEP;
      rvex_pkg::KIND_LOAD,
      rvex_pkg::KIND_ALU_IMM: opb = dec.imm_i;
      rvex_pkg::KIND_STORE:   opb = dec.imm_s;
      default:                opb = src2_value;
    endcase
  end

  // shared add/sub
  assign sub = (dec.kind == rvex_pkg::KIND_ALU_REG) && dec.alt &&
               (dec.funct3 == rvex_pkg::F3_ADD);
  assign sum = sub ? (opa - opb) : (opa + opb);

  // compares shared by set-less-than and branches
  assign eq  = (src1_value == opb);
  assign lt  = ($signed(src1_value) < $signed(opb));
  assign ltu = (src1_value < opb);

  assign shamt = opb[rvex_pkg::SHAMT_W-1:0];

  // alu function
  always_comb begin
    unique case (dec.funct3)
      rvex_pkg::F3_ADD:  alu_out = sum;
      rvex_pkg::F3_SLL:  alu_out = src1_value << shamt;
      rvex_pkg::F3_SLT:  alu_out = {31'b0, lt};
      rvex_pkg::F3_SLTU: alu_out = {31'b0, ltu};
      rvex_pkg::F3_XOR:  alu_out = src1_value ^ opb;
      rvex_pkg::F3_SR:   alu_out = dec.alt ? $unsigned($signed(src1_value) >>> shamt)
                                           : (src1_value >> shamt);
      rvex_pkg::F3_OR:   alu_out = src1_value | opb;
      rvex_pkg::F3_AND:  alu_out = src1_value & opb;
      default:           alu_out = 32'b0;
    endcase
  end

  // branch condition
  always_comb begin
    unique case (dec.funct3)
      rvex_pkg::F3_BEQ:  taken = eq;
      rvex_pkg::F3_BNE:  taken = !eq;
      rvex_pkg::F3_BLT:  taken = lt;
      rvex_pkg::F3_BGE:  taken = !lt;
      rvex_pkg::F3_BLTU: taken = ltu;
      rvex_pkg::F3_BGEU: taken = !ltu;
      default:           taken = 1'b0;
    endcase
  end

  // target adder
  always_comb begin
    tgt_a = instr_pc;
    tgt_b = dec.imm_b;
    if (dec.kind == rvex_pkg::KIND_JAL) begin
      tgt_b = dec.imm_j;
    end else if (dec.kind == rvex_pkg::KIND_JALR) begin
      tgt_a = src1_value;
      tgt_b = dec.imm_i;
    end
  end
  assign tgt_sum = tgt_a + tgt_b;

  // result fields per instruction class
  always_comb begin
    res = '0;
    unique case (dec.kind)
      rvex_pkg::KIND_LUI: begin
        res.alu_value  = dec.imm_u;
        res.dest_write = 1'b1;
      end
      rvex_pkg::KIND_AUIPC: begin
        res.alu_value  = sum;
        res.dest_write = 1'b1;
      end
      rvex_pkg::KIND_JAL: begin
        res.alu_value   = sum;
        res.dest_write  = 1'b1;
        res.branch_flag = 1'b1;
        res.taken_flag  = 1'b1;
        res.target_addr = tgt_sum;
      end
      rvex_pkg::KIND_JALR: begin
        res.alu_value   = sum;
        res.dest_write  = 1'b1;
        res.branch_flag = 1'b1;
        res.taken_flag  = 1'b1;
        res.target_addr = {tgt_sum[31:1], 1'b0};
      end
      rvex_pkg::KIND_BRANCH: begin
        res.branch_flag = 1'b1;
        res.taken_flag  = taken;
        res.target_addr = tgt_sum;
      end
      rvex_pkg::KIND_LOAD: begin
        res.alu_value  = sum;
        res.dest_write = 1'b1;
        res.load_flag  = 1'b1;
      end
      rvex_pkg::KIND_STORE: begin
        res.alu_value  = sum;
        res.store_flag = 1'b1;
        res.store_data = src2_value;
      end
      rvex_pkg::KIND_ALU_IMM,
      rvex_pkg::KIND_ALU_REG: begin
        res.alu_value  = alu_out;
        res.dest_write = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rvex_checker.sv @@
// port-level checks for the execute unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rvex_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_branch,
  input logic        out_taken,
  input logic [31:0] out_alu
);

  logic in_accept;

  assign in_accept = in_valid && in_ready;

  // reset leaves no result pending
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !out_valid, "result valid right after reset")

  // an accepted request moves through the input register into the result register when the output drains
  `ASSERT_CLK_RST(a_latency, clk, rst, in_accept ##1 out_ready |=> out_valid,
                  "request did not reach the result register in time")

  // only branch-class results may be taken
  `ASSERT_CLK_RST(a_taken_branch, clk, rst, out_valid |-> (!out_taken || out_branch),
                  "taken result without branch flag")

  // stalled result holds
  `ASSERT_CLK_RST(a_stall_hold, clk, rst,
                  out_valid && !out_ready |=> out_valid && $stable(out_alu),
                  "stalled result changed")

endmodule

bind rv32i_execute_unit_top rvex_checker u_rvex_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (issue.valid),
  .in_ready   (issue.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_branch (result.branch_flag),
  .out_taken  (result.taken_flag),
  .out_alu    (result.alu_value)
);

`default_nettype wire
